// ===== rtl/core/kfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Kuwahara filter package
// Shared sizes, beat types, state encodings and the line store address map.
// ----------------------------------------------------------------------------
package kfr_pkg;

  // Frame and window limits.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_RADIUS = 8;
  localparam int unsigned ROW_SLOTS  = 2 * MAX_RADIUS + 2;

  // Fixed widths of the configuration registers and of one pixel word.
  localparam int unsigned RAD_W  = 4;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned CFG_AW = 2;

  localparam int unsigned COORD_W = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
  localparam int unsigned SLOT_W  = $clog2(ROW_SLOTS);
  localparam int unsigned DEPTH   = ROW_SLOTS * MAX_WIDTH;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);

  // Quadrant statistics sizes.
  localparam int unsigned NUM_Q  = 4;
  localparam int unsigned Q_W    = 2;
  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_W   = 2;
  localparam int unsigned NMAX   = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
  localparam int unsigned N_W    = $clog2(NMAX + 1);
  localparam int unsigned S_W    = $clog2(NMAX * 255 + 1);
  localparam int unsigned SQ_W   = $clog2(NMAX * 65025 + 1);
  localparam int unsigned P_W    = N_W + SQ_W;
  localparam int unsigned V_W    = P_W + 2;
  localparam int unsigned N2_W   = 2 * N_W;
  localparam int unsigned CMP_W  = V_W + N2_W;
  localparam int unsigned BIT_W  = $clog2(S_W);
  localparam int unsigned DRN_W  = $clog2(NUM_Q + 1);

  typedef enum logic [CFG_AW-1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_SELECT,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    SL_IDLE,
    SL_N2,
    SL_MUL,
    SL_ACC,
    SL_CMP,
    SL_PICK,
    SL_DIV,
    SL_DONE
  } sel_state_e;

  // One pixel travelling down the cell chain.
  typedef struct packed {
    logic                           valid;
    logic [COORD_W-1:0]             x;
    logic [COORD_W-1:0]             y;
    logic [NUM_CH-1:0][CHAN_W-1:0]  rgb;
  } pix_t;

  // Inclusive bounds of one quadrant window.
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } box_t;

  // Pixel count, sums and sums of squares of one quadrant.
  typedef struct packed {
    logic [N_W-1:0]                n;
    logic [NUM_CH-1:0][S_W-1:0]    s;
    logic [NUM_CH-1:0][SQ_W-1:0]   sq;
  } stats_t;

  // Line store address of a column within a row slot.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0]  slot,
                                                  input logic [COORD_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/core/kuwahara_filter_rgb.sv =====
// ----------------------------------------------------------------------------
// Kuwahara filter, RGBA stream
// Each output pixel takes the mean RGB of its least-variance quadrant window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and leave in raster order, each as soon as the
// last pixel of its window has arrived; drain beats flush the remaining rows
// at the end of a frame. An input beat that releases no output only passes the
// check state. One that releases an output then scans, drains, selects and
// emits, the last once the output register is free; the scan reads the clipped
// (2r+1)x(2r+1) window around the pixel from the line store one pixel per
// cycle, through the single read port of the store, into a
// chain of four quadrant cells, and the quadrant compare and the three mean
// divisions then share one multiplier set and a bit-serial divider. The line
// store needs no clearing after reset. Writing any register restarts the frame.
// ----------------------------------------------------------------------------
module kuwahara_filter_rgb import kfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic              s_axis_tuser,   // kind
  // Output stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic              m_axis_tlast,   // frame_end
  // Register writes.
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [DIM_W-1:0]  cfg_data_i
);

  ctrl_state_e state_q, state_d;

  logic [RAD_W-1:0]   radius_q;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [RAD_W-1:0]   r_eff;
  logic [DIM_W-1:0]   w_eff, h_eff;

  logic [COORD_W-1:0] in_col_q, in_row_q, out_col_q, out_row_q;
  logic [SLOT_W-1:0]  in_slot_q, out_slot_q;
  logic               in_done_q;

  logic [COORD_W-1:0] sx_q, sy_q, wx0_q, wx1_q, wy0_q, wy1_q;
  logic [SLOT_W-1:0]  ss_q;
  logic               tag_valid_q;
  logic [COORD_W-1:0] tag_x_q, tag_y_q;
  logic [DRN_W-1:0]   drn_q;
  logic [CHAN_W-1:0]  alpha_q;

  logic               m_valid_q, m_last_q;
  logic [PIX_W-1:0]   m_data_q;

  // Effective register values.
  always_comb begin
    r_eff = (radius_q == '0) ? RAD_W'(1) :
            (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
    w_eff = (width_q == '0) ? DIM_W'(1) :
            (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
    h_eff = (height_q == '0) ? DIM_W'(1) :
            (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
  end

  // Input beat and the line store write.
  logic               acc, store, wrap;
  logic [COORD_W-1:0] cur_col, cur_row;
  logic [SLOT_W-1:0]  cur_slot;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign store = acc && (s_axis_tuser == KIND_PIXEL) && !in_done_q;

  always_comb begin
    wrap     = DIM_W'(in_col_q) >= w_eff || DIM_W'(in_row_q) >= h_eff;
    cur_col  = wrap ? '0 : in_col_q;
    cur_row  = wrap ? '0 : in_row_q;
    cur_slot = wrap ? '0 : in_slot_q;
  end

  // Window of the next output pixel.
  logic [DIM_W-1:0]   xr, yr;
  logic [COORD_W-1:0] tx, ty, xa, ya;
  logic [SLOT_W-1:0]  dy, start_slot;
  logic               out_ok, rcvd, go;

  always_comb begin
    out_ok = DIM_W'(out_col_q) < w_eff && DIM_W'(out_row_q) < h_eff;
    xr = DIM_W'(out_col_q) + DIM_W'(r_eff);
    yr = DIM_W'(out_row_q) + DIM_W'(r_eff);
    tx = (xr > w_eff - DIM_W'(1)) ? COORD_W'(w_eff - DIM_W'(1)) : COORD_W'(xr);
    ty = (yr > h_eff - DIM_W'(1)) ? COORD_W'(h_eff - DIM_W'(1)) : COORD_W'(yr);
    xa = (DIM_W'(out_col_q) >= DIM_W'(r_eff)) ? out_col_q - COORD_W'(r_eff) : '0;
    ya = (DIM_W'(out_row_q) >= DIM_W'(r_eff)) ? out_row_q - COORD_W'(r_eff) : '0;
    dy = SLOT_W'(out_row_q - ya);
    start_slot = (out_slot_q >= dy) ? out_slot_q - dy :
                 SLOT_W'((SLOT_W+1)'(out_slot_q) + (SLOT_W+1)'(ROW_SLOTS) - (SLOT_W+1)'(dy));
    rcvd = in_done_q || in_row_q > ty || (in_row_q == ty && in_col_q > tx);
    go   = out_ok && rcvd;
  end

  // Line store.
  logic [PIX_W-1:0] rdata;

  kfr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (slot_addr(cur_slot, cur_col)),
    .wdata_i (s_axis_tdata),
    .raddr_i (slot_addr(ss_q, sx_q)),
    .rdata_o (rdata)
  );

  // Quadrant cell chain.
  pix_t   chain [NUM_Q+1];
  stats_t stats [NUM_Q];
  stats_t [NUM_Q-1:0] stats_vec;
  logic   [NUM_Q:0]   busy;
  logic   clear_cells, sel_start, sel_done, load_out;
  logic   [NUM_CH-1:0][CHAN_W-1:0] mean;

  assign chain[0] = '{valid: tag_valid_q, x: tag_x_q, y: tag_y_q,
                      rgb: rdata[NUM_CH*CHAN_W-1:0]};

  for (genvar q = 0; q < NUM_Q; q++) begin : g_cell
    box_t box;
    assign box.x0 = (q % 2 == 1) ? out_col_q : wx0_q;
    assign box.x1 = (q % 2 == 1) ? wx1_q : out_col_q;
    assign box.y0 = (q / 2 == 1) ? out_row_q : wy0_q;
    assign box.y1 = (q / 2 == 1) ? wy1_q : out_row_q;

    kfr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear_cells),
      .box_i   (box),
      .pix_i   (chain[q]),
      .pix_o   (chain[q+1]),
      .stats_o (stats[q])
    );
    assign stats_vec[q] = stats[q];
  end

  for (genvar k = 0; k <= NUM_Q; k++) begin : g_busy
    assign busy[k] = chain[k].valid;
  end

  kfr_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sel_start),
    .stats_i (stats_vec),
    .done_o  (sel_done),
    .mean_o  (mean)
  );

  // Control sequence.
  logic scan_last;
  assign scan_last = (sx_q == wx1_q) && (sy_q == wy1_q);

  always_comb begin
    state_d     = state_q;
    clear_cells = 1'b0;
    sel_start   = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      ST_IDLE:  if (acc) state_d = ST_CHECK;
      ST_CHECK: begin
        clear_cells = go;
        state_d     = go ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (drn_q == DRN_W'(NUM_Q)) begin
          sel_start = 1'b1;
          state_d   = ST_SELECT;
        end
      end
      ST_SELECT: if (sel_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Registers and frame positions.
  logic out_col_end, out_row_end;
  assign out_col_end = DIM_W'(out_col_q) + DIM_W'(1) >= w_eff;
  assign out_row_end = DIM_W'(out_row_q) + DIM_W'(1) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RAD_W'(1);
      width_q    <= DIM_W'(MAX_WIDTH);
      height_q   <= DIM_W'(MAX_HEIGHT);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else if (cfg_we_i && (cfg_addr_i == REG_RADIUS || cfg_addr_i == REG_WIDTH ||
                              cfg_addr_i == REG_HEIGHT)) begin
      case (cfg_addr_i)
        REG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else begin
      if (store) begin
        if (DIM_W'(cur_col) + DIM_W'(1) >= w_eff) begin
          in_col_q <= '0;
          if (DIM_W'(cur_row) + DIM_W'(1) >= h_eff) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
            in_done_q <= 1'b1;
          end else begin
            in_row_q  <= cur_row + COORD_W'(1);
            in_slot_q <= (cur_slot == SLOT_W'(ROW_SLOTS - 1)) ? '0 : cur_slot + SLOT_W'(1);
          end
        end else begin
          in_col_q <= cur_col + COORD_W'(1);
          in_row_q <= cur_row;
          in_slot_q <= cur_slot;
        end
      end
      if (load_out) begin
        if (out_col_end) begin
          out_col_q <= '0;
          if (out_row_end) begin
            out_row_q  <= '0;
            out_slot_q <= '0;
            in_done_q  <= 1'b0;
          end else begin
            out_row_q  <= out_row_q + COORD_W'(1);
            out_slot_q <= (out_slot_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 :
                          out_slot_q + SLOT_W'(1);
          end
        end else begin
          out_col_q <= out_col_q + COORD_W'(1);
        end
      end
    end
  end

  // Window scan: one line store read per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_valid_q <= 1'b0;
      drn_q       <= '0;
    end else begin
      tag_valid_q <= (state_q == ST_SCAN);
      drn_q       <= (state_q == ST_DRAIN) ? drn_q + DRN_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_x_q <= sx_q;
    tag_y_q <= sy_q;
    if (state_q == ST_CHECK) begin
      wx0_q <= xa;
      wx1_q <= tx;
      wy0_q <= ya;
      wy1_q <= ty;
      sx_q  <= xa;
      sy_q  <= ya;
      ss_q  <= start_slot;
    end else if (state_q == ST_SCAN) begin
      if (sx_q == wx1_q) begin
        sx_q <= wx0_q;
        sy_q <= sy_q + COORD_W'(1);
        ss_q <= (ss_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 : ss_q + SLOT_W'(1);
      end else begin
        sx_q <= sx_q + COORD_W'(1);
      end
    end
    // Alpha of the center pixel as it passes.
    if (tag_valid_q && tag_x_q == out_col_q && tag_y_q == out_row_q) begin
      alpha_q <= rdata[PIX_W-1:PIX_W-CHAN_W];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {alpha_q, mean[2], mean[1], mean[0]};
      m_last_q <= out_col_end && out_row_end;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // Checks.
  // The last cell has accumulated its final pixel; only its pass-on stage may
  // still hold it.
  a_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_start |-> busy[NUM_Q-1:0] == '0)
    else $error("quadrant chain still busy at select start");

  a_done_in_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_done |-> state_q == ST_SELECT)
    else $error("selector finished outside select phase");

  a_emit_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_ok)
    else $error("output pixel outside the frame");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> sx_q <= wx1_q && sy_q <= wy1_q)
    else $error("scan left its window");

endmodule

// ===== rtl/core/kfr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module kfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/kfr_cell.sv =====
// ----------------------------------------------------------------------------
// Kuwahara quadrant cell
// Accumulates the statistics of one quadrant window from the passing pixels
// and hands each pixel on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module kfr_cell import kfr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   clear_i,
  input  box_t   box_i,
  input  pix_t   pix_i,
  output pix_t   pix_o,
  output stats_t stats_o
);

  pix_t   pix_q;
  stats_t stats_q;
  logic   hit;

  // The pixel belongs to this window.
  assign hit = pix_i.valid &&
               pix_i.x >= box_i.x0 && pix_i.x <= box_i.x1 &&
               pix_i.y >= box_i.y0 && pix_i.y <= box_i.y1;

  // Pass-on stage and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q   <= '0;
      stats_q <= '0;
    end else begin
      pix_q <= pix_i;
      if (clear_i) begin
        stats_q <= '0;
      end else if (hit) begin
        stats_q.n <= stats_q.n + N_W'(1);
        for (int c = 0; c < NUM_CH; c++) begin
          stats_q.s[c]  <= stats_q.s[c] + S_W'(pix_i.rgb[c]);
          stats_q.sq[c] <= stats_q.sq[c] + SQ_W'(pix_i.rgb[c] * pix_i.rgb[c]);
        end
      end
    end
  end

  assign pix_o   = pix_q;
  assign stats_o = stats_q;

endmodule

// ===== rtl/core/kfr_select.sv =====
// ----------------------------------------------------------------------------
// Kuwahara quadrant selector
// Compares the quadrant variances exactly by cross-multiplication and divides
// the sums of the winner by its pixel count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfr_select import kfr_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  stats_t [NUM_Q-1:0]               stats_i,
  output logic                             done_o,
  output logic [NUM_CH-1:0][CHAN_W-1:0]    mean_o
);

  sel_state_e state_q, state_d;

  logic [Q_W-1:0]   q_q;
  logic [CH_W-1:0]  c_q;
  logic [Q_W-1:0]   best_q;
  logic [V_W-1:0]   v_q, bv_q;
  logic [N2_W-1:0]  n2_q, bn2_q;
  logic [P_W-1:0]   p1_q, p2_q;
  logic [CMP_W-1:0] lhs_q, rhs_q;
  logic [BIT_W-1:0] bit_q;
  logic [N_W-1:0]   rem_q;
  logic [S_W-1:0]   quo_q;
  logic [NUM_CH-1:0][CHAN_W-1:0] mean_q;

  stats_t         cur, win;
  logic [N_W:0]   trial;
  logic           take;
  logic [N_W-1:0] rem_next;
  logic [S_W-1:0] quo_next;

  assign cur = stats_i[q_q];
  assign win = stats_i[best_q];

  // Restoring division step on the winning sums.
  always_comb begin
    trial    = {rem_q, win.s[c_q][bit_q]};
    take     = trial >= (N_W+1)'(win.n);
    rem_next = take ? N_W'(trial - (N_W+1)'(win.n)) : trial[N_W-1:0];
    quo_next = {quo_q[S_W-2:0], take};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    case (state_q)
      SL_IDLE: if (start_i) state_d = SL_N2;
      SL_N2:   state_d = SL_MUL;
      SL_MUL:  state_d = SL_ACC;
      SL_ACC:  state_d = (c_q == CH_W'(NUM_CH - 1)) ? SL_CMP : SL_MUL;
      SL_CMP:  state_d = SL_PICK;
      SL_PICK: state_d = (q_q == Q_W'(NUM_Q - 1)) ? SL_DIV : SL_N2;
      SL_DIV: begin
        if (bit_q == '0 && c_q == CH_W'(NUM_CH - 1)) state_d = SL_DONE;
      end
      SL_DONE: begin
        done_o  = 1'b1;
        state_d = SL_IDLE;
      end
      default: state_d = SL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      SL_IDLE: begin
        q_q <= '0;
      end
      SL_N2: begin
        n2_q <= N2_W'(cur.n * cur.n);
        v_q  <= '0;
        c_q  <= '0;
      end
      SL_MUL: begin
        p1_q <= P_W'(cur.n * cur.sq[c_q]);
        p2_q <= P_W'(cur.s[c_q] * cur.s[c_q]);
      end
      SL_ACC: begin
        v_q <= v_q + V_W'(p1_q - p2_q);
        c_q <= c_q + CH_W'(1);
      end
      SL_CMP: begin
        lhs_q <= CMP_W'(v_q * bn2_q);
        rhs_q <= CMP_W'(bv_q * n2_q);
      end
      SL_PICK: begin
        // The earlier quadrant wins a tie.
        if (q_q == '0 || lhs_q < rhs_q) begin
          best_q <= q_q;
          bv_q   <= v_q;
          bn2_q  <= n2_q;
        end
        q_q   <= q_q + Q_W'(1);
        c_q   <= '0;
        bit_q <= BIT_W'(S_W - 1);
        rem_q <= '0;
        quo_q <= '0;
      end
      SL_DIV: begin
        if (bit_q == '0) begin
          mean_q[c_q] <= quo_next[CHAN_W-1:0];
          c_q         <= c_q + CH_W'(1);
          bit_q       <= BIT_W'(S_W - 1);
          rem_q       <= '0;
          quo_q       <= '0;
        end else begin
          rem_q <= rem_next;
          quo_q <= quo_next;
          bit_q <= bit_q - BIT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign mean_o = mean_q;

endmodule
